// ===== src/uart_pkg.sv =====
// uart_pkg: opcodes, register indexes, status bit positions and defaults
// for the serial port block. No dependencies.
package uart_pkg;

  localparam int unsigned DivisorBitsDef = 16;
  localparam int unsigned CfgWidth       = 16;
  localparam int unsigned CfgAddrWidth   = 3;
  localparam int unsigned WordWidth      = 9;

  // item opcodes
  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_STATUS_READ = 2'd1;
  localparam logic [1:0] OP_DATA_READ   = 2'd2;
  localparam logic [1:0] OP_DATA_WRITE  = 2'd3;

  // configuration register indexes
  localparam logic [CfgAddrWidth-1:0] REG_BAUD_DIVISOR   = 3'd0;
  localparam logic [CfgAddrWidth-1:0] REG_OVERSAMPLE_BY8 = 3'd1;
  localparam logic [CfgAddrWidth-1:0] REG_WORD_LENGTH_9  = 3'd2;
  localparam logic [CfgAddrWidth-1:0] REG_STOP_BITS      = 3'd3;
  localparam logic [CfgAddrWidth-1:0] REG_RX_ENABLE      = 3'd4;
  localparam logic [CfgAddrWidth-1:0] REG_TX_ENABLE      = 3'd5;
  localparam logic [CfgAddrWidth-1:0] REG_PORT_ENABLE    = 3'd6;
  localparam logic [CfgAddrWidth-1:0] REG_RX_IRQ_ENABLE  = 3'd7;

  // status word bit positions
  localparam int unsigned STAT_TXE  = 7;
  localparam int unsigned STAT_TC   = 6;
  localparam int unsigned STAT_RXNE = 5;
  localparam int unsigned STAT_ORE  = 3;
  localparam int unsigned STAT_FE   = 1;

  // stop bit codes
  localparam logic [1:0] STOP_ONE      = 2'd0;
  localparam logic [1:0] STOP_HALF     = 2'd1;
  localparam logic [1:0] STOP_TWO      = 2'd2;
  localparam logic [1:0] STOP_ONE_HALF = 2'd3;

  // number of stop segments after the data bits
  function automatic logic [3:0] stop_segments(input logic [1:0] stop);
    logic [3:0] r;
    case (stop)
      STOP_ONE, STOP_HALF:     r = 4'd1;
      STOP_TWO, STOP_ONE_HALF: r = 4'd2;
      default:                 r = 4'd1;
    endcase
    return r;
  endfunction

  // first stop segment lasts half a bit period
  function automatic logic half_first_stop(input logic [1:0] stop);
    return (stop == STOP_HALF) || (stop == STOP_ONE_HALF);
  endfunction

endpackage

// ===== src/uart_peripheral.sv =====
// uart_peripheral: serial port with fractional baud divisor, 8/9 data bits.
// Depends on uart_pkg.
//
// Every item (tick, status read, data read, data write) is taken into an
// input register, processed by one pass of logic that updates the port state,
// and its result lands in an output register: one item per clock. The result
// is registered in the output register when the item leaves the input register,
// which a stall at the output can delay. While a result waits, the input
// register can still take one item; with both registers full the input stalls
// until the result is taken. Configuration is written through a plain write
// port and should only change when no transaction is in flight.
module uart_peripheral
  import uart_pkg::*;
#(
  parameter int unsigned DIVISOR_BITS = DivisorBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgWidth-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  input  logic [WordWidth-1:0]    tx_data_i,
  input  logic                    rx_line_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [WordWidth-1:0]    read_data_o,
  output logic                    tx_line_o,
  output logic                    irq_o
);

  localparam int unsigned DB = DIVISOR_BITS;
  localparam int unsigned PW = (DB > CfgWidth) ? DB : CfgWidth;
  localparam logic [PW-1:0] PeriodMax = PW'({DB{1'b1}});

  // configuration
  logic [CfgWidth-1:0] div_q;
  logic over8_q, word9_q, rxen_q, txen_q, porten_q, irqen_q;
  logic [1:0] stop_q;

  // pipeline
  logic in_vld_q, out_vld_q, advance;
  logic [1:0] op_q;
  logic [WordWidth-1:0] data_q;
  logic line_q;
  logic [WordWidth-1:0] rd_q;
  logic txl_q, irq_q;

  // port state
  logic [WordWidth-1:0] tx_hold_q, tx_hold_d, tx_sh_q, tx_sh_d;
  logic tx_hf_q, tx_hf_d, tx_busy_q, tx_busy_d, tx_tc_q, tx_tc_d;
  logic [3:0] tx_cnt_q, tx_cnt_d;
  logic [DB-1:0] tx_tmr_q, tx_tmr_d;
  logic [WordWidth-1:0] rx_sh_q, rx_sh_d, rx_word_q, rx_word_d;
  logic rx_busy_q, rx_busy_d, rxne_q, rxne_d, ore_q, ore_d, fe_q, fe_d;
  logic seen_q, seen_d, rx_last_q, rx_last_d;
  logic [3:0] rx_cnt_q, rx_cnt_d;
  logic [DB-1:0] rx_tmr_q, rx_tmr_d;
  logic [WordWidth-1:0] rd_d;
  logic txl_d, irq_d;

  // bit period in clocks, clamped
  logic [PW-1:0] raw_period, lo_period, clamp_period;
  logic [DB-1:0] period;

  always_comb begin
    if (over8_q) begin
      raw_period = PW'({div_q[15:4], 3'b000}) + PW'(div_q[2:0]);
      lo_period  = PW'(8);
    end else begin
      raw_period = PW'(div_q);
      lo_period  = PW'(16);
    end
    if (raw_period < lo_period) begin
      clamp_period = lo_period;
    end else if (raw_period > PeriodMax) begin
      clamp_period = PeriodMax;
    end else begin
      clamp_period = raw_period;
    end
    period = clamp_period[DB-1:0];
  end

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // one pass over the item in the input register
  always_comb begin
    logic [3:0] nbits, last;
    logic [WordWidth-1:0] mask;
    logic [DB-1:0] len, tmr_inc, rtmr_inc;
    logic tx_run, lvl;

    nbits = word9_q ? 4'd9 : 4'd8;
    mask  = word9_q ? 9'h1FF : 9'h0FF;
    last  = nbits + stop_segments(stop_q);

    tx_hold_d = tx_hold_q;
    tx_hf_d   = tx_hf_q;
    tx_sh_d   = tx_sh_q;
    tx_busy_d = tx_busy_q;
    tx_tc_d   = tx_tc_q;
    tx_cnt_d  = tx_cnt_q;
    tx_tmr_d  = tx_tmr_q;
    rx_sh_d   = rx_sh_q;
    rx_word_d = rx_word_q;
    rx_busy_d = rx_busy_q;
    rxne_d    = rxne_q;
    ore_d     = ore_q;
    fe_d      = fe_q;
    seen_d    = seen_q;
    rx_last_d = rx_last_q;
    rx_cnt_d  = rx_cnt_q;
    rx_tmr_d  = rx_tmr_q;
    rd_d      = '0;
    len       = period;
    tmr_inc   = '0;
    rtmr_inc  = '0;
    tx_run    = 1'b0;

    case (op_q)
      OP_TICK: begin
        tx_run = porten_q && txen_q && (tx_busy_q || tx_hf_q);
        if (tx_run && !tx_busy_q) begin
          tx_sh_d   = tx_hold_q & mask;
          tx_hf_d   = 1'b0;
          tx_busy_d = 1'b1;
          tx_cnt_d  = '0;
          tx_tmr_d  = '0;
        end
      end
      OP_STATUS_READ: begin
        rd_d            = '0;
        rd_d[STAT_TXE]  = !tx_hf_q;
        rd_d[STAT_TC]   = tx_tc_q;
        rd_d[STAT_RXNE] = rxne_q;
        rd_d[STAT_ORE]  = ore_q;
        rd_d[STAT_FE]   = fe_q;
        seen_d          = 1'b1;
      end
      OP_DATA_READ: begin
        rd_d   = rx_word_q;
        rxne_d = 1'b0;
        if (seen_q) begin
          ore_d = 1'b0;
          fe_d  = 1'b0;
        end
        seen_d = 1'b0;
      end
      OP_DATA_WRITE: begin
        tx_hold_d = data_q;
        tx_hf_d   = 1'b1;
        tx_tc_d   = 1'b0;
      end
      default: begin
        rd_d = '0;
      end
    endcase

    // line level after any load, before the timer moves
    if (!(porten_q && txen_q) || !tx_busy_d) begin
      lvl = 1'b1;
    end else if (tx_cnt_d == 4'd0) begin
      lvl = 1'b0;
    end else if (tx_cnt_d <= nbits) begin
      lvl = tx_sh_d[tx_cnt_d - 4'd1];
    end else begin
      lvl = 1'b1;
    end
    txl_d = lvl;

    if (tx_run) begin
      if (half_first_stop(stop_q) && (tx_cnt_d == nbits + 4'd1)) begin
        len = period >> 1;
      end
      tmr_inc = tx_tmr_d + DB'(1);
      if (tmr_inc >= len) begin
        tx_tmr_d = '0;
        if (tx_cnt_d >= last) begin
          if (tx_hf_d) begin
            tx_sh_d   = tx_hold_d & mask;
            tx_hf_d   = 1'b0;
            tx_busy_d = 1'b1;
            tx_cnt_d  = '0;
          end else begin
            tx_busy_d = 1'b0;
            tx_tc_d   = 1'b1;
          end
        end else begin
          tx_cnt_d = tx_cnt_d + 4'd1;
        end
      end else begin
        tx_tmr_d = tmr_inc;
      end
    end

    if ((op_q == OP_TICK) && porten_q && rxen_q) begin
      if (!rx_busy_q) begin
        if (rx_last_q && !line_q) begin
          rx_busy_d = 1'b1;
          rx_cnt_d  = '0;
          rx_tmr_d  = DB'(1);
          rx_sh_d   = '0;
        end
      end else begin
        // mid-bit sample
        if (rx_tmr_q == (period >> 1)) begin
          if (rx_cnt_q == 4'd0) begin
            if (line_q) begin
              rx_busy_d = 1'b0;
            end
          end else if (rx_cnt_q <= nbits) begin
            rx_sh_d[rx_cnt_q - 4'd1] = line_q;
          end else begin
            if (!line_q) begin
              fe_d = 1'b1;
            end
            if (rxne_q) begin
              ore_d = 1'b1;
            end else begin
              rx_word_d = rx_sh_q & mask;
              rxne_d    = 1'b1;
            end
            rx_busy_d = 1'b0;
          end
        end
        if (rx_busy_d) begin
          rtmr_inc = rx_tmr_q + DB'(1);
          if (rtmr_inc >= period) begin
            rx_tmr_d = '0;
            rx_cnt_d = rx_cnt_q + 4'd1;
          end else begin
            rx_tmr_d = rtmr_inc;
          end
        end
      end
      rx_last_d = line_q;
    end

    irq_d = irqen_q && (rxne_d || ore_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= '0;
      over8_q  <= 1'b0;
      word9_q  <= 1'b0;
      stop_q   <= STOP_ONE;
      rxen_q   <= 1'b0;
      txen_q   <= 1'b0;
      porten_q <= 1'b0;
      irqen_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BAUD_DIVISOR:   div_q    <= cfg_wdata_i;
        REG_OVERSAMPLE_BY8: over8_q  <= cfg_wdata_i[0];
        REG_WORD_LENGTH_9:  word9_q  <= cfg_wdata_i[0];
        REG_STOP_BITS:      stop_q   <= cfg_wdata_i[1:0];
        REG_RX_ENABLE:      rxen_q   <= cfg_wdata_i[0];
        REG_TX_ENABLE:      txen_q   <= cfg_wdata_i[0];
        REG_PORT_ENABLE:    porten_q <= cfg_wdata_i[0];
        REG_RX_IRQ_ENABLE:  irqen_q  <= cfg_wdata_i[0];
        default:            div_q    <= div_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= opcode_i;
      data_q <= tx_data_i;
      line_q <= rx_line_i;
    end
    if (advance) begin
      rd_q  <= rd_d;
      txl_q <= txl_d;
      irq_q <= irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q <= '0;
      tx_hf_q   <= 1'b0;
      tx_sh_q   <= '0;
      tx_busy_q <= 1'b0;
      tx_tc_q   <= 1'b1;
      tx_cnt_q  <= '0;
      tx_tmr_q  <= '0;
      rx_sh_q   <= '0;
      rx_word_q <= '0;
      rx_busy_q <= 1'b0;
      rxne_q    <= 1'b0;
      ore_q     <= 1'b0;
      fe_q      <= 1'b0;
      seen_q    <= 1'b0;
      rx_last_q <= 1'b1;
      rx_cnt_q  <= '0;
      rx_tmr_q  <= '0;
    end else if (advance) begin
      tx_hold_q <= tx_hold_d;
      tx_hf_q   <= tx_hf_d;
      tx_sh_q   <= tx_sh_d;
      tx_busy_q <= tx_busy_d;
      tx_tc_q   <= tx_tc_d;
      tx_cnt_q  <= tx_cnt_d;
      tx_tmr_q  <= tx_tmr_d;
      rx_sh_q   <= rx_sh_d;
      rx_word_q <= rx_word_d;
      rx_busy_q <= rx_busy_d;
      rxne_q    <= rxne_d;
      ore_q     <= ore_d;
      fe_q      <= fe_d;
      seen_q    <= seen_d;
      rx_last_q <= rx_last_d;
      rx_cnt_q  <= rx_cnt_d;
      rx_tmr_q  <= rx_tmr_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = rd_q;
  assign tx_line_o   = txl_q;
  assign irq_o       = irq_q;

  // a finished transmission leaves nothing queued or in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_tc_q |-> (!tx_busy_q && !tx_hf_q))
    else $error("transmission complete with work pending");

  // the frame counter never runs past the longest frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_busy_q |-> (tx_cnt_q <= 4'd11))
    else $error("transmit bit counter out of range");

  // port state only moves when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(rxne_q) && $stable(tx_busy_q) && $stable(rx_busy_q)))
    else $error("state changed without a transaction");

  // a waiting item stays in the input register until it moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("input item lost");

  // a result is produced exactly when an item moves out of the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result missing after transaction");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for uart_peripheral, with an in-bench model of the
// serial port, a random line stimulus and random stalls on both handshakes.
// Depends on uart_pkg and uart_peripheral.
module testbench;
  import uart_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned MaxShown      = 100;
  localparam int unsigned LatencySettle = 4;
  localparam int unsigned PhaseCount    = 14;
  localparam int unsigned HoldCycles    = 120;

  typedef struct packed {
    logic [WordWidth-1:0] read_data;
    logic                 tx_line;
    logic                 irq;
  } uart_reply_t;

  // tracks the port state and the replies still owed by the block
  class uart_tracker;
    logic [15:0] divisor;
    logic        by8, nine_bits, rx_en, tx_en, port_en, irq_en;
    logic [1:0]  stops;
    logic [8:0]  hold_word, tx_shift, rx_shift, rx_data;
    logic        hold_full, tx_active, tx_done;
    logic [3:0]  tx_bits, rx_bits;
    logic [15:0] tx_cnt, rx_cnt;
    logic        rx_active, rxne, ore, fe, status_read, line_prev;
    uart_reply_t pending_replies[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      divisor = '0;
      by8 = 1'b0;
      nine_bits = 1'b0;
      stops = STOP_ONE;
      rx_en = 1'b0;
      tx_en = 1'b0;
      port_en = 1'b0;
      irq_en = 1'b0;
      hold_word = '0;
      hold_full = 1'b0;
      tx_shift = '0;
      tx_bits = '0;
      tx_cnt = '0;
      tx_active = 1'b0;
      tx_done = 1'b1;
      rx_shift = '0;
      rx_bits = '0;
      rx_cnt = '0;
      rx_active = 1'b0;
      rx_data = '0;
      rxne = 1'b0;
      ore = 1'b0;
      fe = 1'b0;
      status_read = 1'b0;
      line_prev = 1'b1;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(input logic [CfgAddrWidth-1:0] idx, input logic [CfgWidth-1:0] value);
      case (idx)
        REG_BAUD_DIVISOR:   divisor = value;
        REG_OVERSAMPLE_BY8: by8 = value[0];
        REG_WORD_LENGTH_9:  nine_bits = value[0];
        REG_STOP_BITS:      stops = value[1:0];
        REG_RX_ENABLE:      rx_en = value[0];
        REG_TX_ENABLE:      tx_en = value[0];
        REG_PORT_ENABLE:    port_en = value[0];
        REG_RX_IRQ_ENABLE:  irq_en = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    // clocks per bit, clamped between the oversampling floor and the divisor maximum
    function int unsigned bit_period();
      int unsigned p, lo;
      if (by8) begin
        p = 8 * divisor[15:4] + divisor[2:0];
        lo = 8;
      end else begin
        p = divisor;
        lo = 16;
      end
      if (p < lo) p = lo;
      if (p > (1 << DivisorBitsDef) - 1) p = (1 << DivisorBitsDef) - 1;
      return p;
    endfunction

    function int unsigned data_bits();
      return nine_bits ? 9 : 8;
    endfunction

    // stop length counted in half bits
    function int unsigned half_stops();
      int unsigned h;
      case (stops)
        STOP_ONE:      h = 2;
        STOP_HALF:     h = 1;
        STOP_TWO:      h = 4;
        STOP_ONE_HALF: h = 3;
        default:       h = 2;
      endcase
      return h;
    endfunction

    function logic tx_level();
      if (!(port_en && tx_en) || !tx_active) return 1'b1;
      if (tx_bits == 0) return 1'b0;
      if (tx_bits <= data_bits()) return tx_shift[tx_bits - 1];
      return 1'b1;
    endfunction

    function void tx_load();
      tx_shift = nine_bits ? hold_word : {1'b0, hold_word[7:0]};
      hold_full = 1'b0;
      tx_active = 1'b1;
      tx_bits = '0;
      tx_cnt = '0;
    endfunction

    function void tx_tick();
      int unsigned n, h, last, p, len;
      n = data_bits();
      h = half_stops();
      last = n + ((h + 1) >> 1);
      p = bit_period();
      if (!tx_active && hold_full) tx_load();
      if (!tx_active) return;
      len = p;
      // first stop segment is half a bit in the half and one-and-a-half modes
      if ((h & 1) && tx_bits == n + 1) len = p >> 1;
      tx_cnt = tx_cnt + 1;
      if (tx_cnt >= len) begin
        tx_cnt = '0;
        if (tx_bits >= last) begin
          if (hold_full) begin
            tx_load();
          end else begin
            tx_active = 1'b0;
            tx_done = 1'b1;
          end
        end else begin
          tx_bits = tx_bits + 1;
        end
      end
    endfunction

    function void rx_sample(input logic lvl);
      int unsigned n;
      n = data_bits();
      if (rx_bits == 0) begin
        // high in mid start bit: false start
        if (lvl) rx_active = 1'b0;
      end else if (rx_bits <= n) begin
        rx_shift[rx_bits - 1] = lvl;
      end else begin
        if (!lvl) fe = 1'b1;
        if (rxne) begin
          ore = 1'b1;
        end else begin
          rx_data = nine_bits ? rx_shift : {1'b0, rx_shift[7:0]};
          rxne = 1'b1;
        end
        rx_active = 1'b0;
      end
    endfunction

    function void rx_tick(input logic lvl);
      int unsigned p;
      p = bit_period();
      if (!rx_active) begin
        if (line_prev && !lvl) begin
          rx_active = 1'b1;
          rx_bits = '0;
          rx_cnt = 16'd1;
          rx_shift = '0;
        end
      end else begin
        if (rx_cnt == (p >> 1)) rx_sample(lvl);
        if (rx_active) begin
          rx_cnt = rx_cnt + 1;
          if (rx_cnt >= p) begin
            rx_cnt = '0;
            rx_bits = rx_bits + 1;
          end
        end
      end
      line_prev = lvl;
    endfunction

    // accepted input transaction: advance the state and queue the reply it owes
    function void take_item(input logic [1:0] op, input logic [8:0] data, input logic lvl);
      uart_reply_t rep;
      rep = '0;
      if (op == OP_TICK) begin
        if (port_en && tx_en && (tx_active || hold_full)) begin
          if (!tx_active) tx_load();
          rep.tx_line = tx_level();
          tx_tick();
        end else begin
          rep.tx_line = tx_level();
        end
        if (port_en && rx_en) rx_tick(lvl);
      end else begin
        case (op)
          OP_STATUS_READ: begin
            rep.read_data[STAT_TXE]  = !hold_full;
            rep.read_data[STAT_TC]   = tx_done;
            rep.read_data[STAT_RXNE] = rxne;
            rep.read_data[STAT_ORE]  = ore;
            rep.read_data[STAT_FE]   = fe;
            status_read = 1'b1;
          end
          OP_DATA_READ: begin
            rep.read_data = rx_data;
            rxne = 1'b0;
            if (status_read) begin
              ore = 1'b0;
              fe = 1'b0;
            end
            status_read = 1'b0;
          end
          default: begin
            hold_word = data;
            hold_full = 1'b1;
            tx_done = 1'b0;
          end
        endcase
        rep.tx_line = tx_level();
      end
      rep.irq = irq_en & (rxne | ore);
      pending_replies.push_back(rep);
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MaxShown) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_reply(input logic [8:0] rd, input logic txl, input logic irq_lvl);
      uart_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with no transaction pending (read_data %h)", rd));
      end else begin
        want = pending_replies.pop_front();
        if (rd !== want.read_data)
          report_mismatch($sformatf("reply %0d read_data %h, want %h", checked, rd,
                                    want.read_data));
        if (txl !== want.tx_line)
          report_mismatch($sformatf("reply %0d tx_line %b, want %b", checked, txl,
                                    want.tx_line));
        if (irq_lvl !== want.irq)
          report_mismatch($sformatf("reply %0d irq %b, want %b", checked, irq_lvl, want.irq));
        checked++;
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [CfgWidth-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              opcode_i = OP_TICK;
  logic [WordWidth-1:0]    tx_data_i = '0;
  logic                    rx_line_i = 1'b1;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [WordWidth-1:0]    read_data_o;
  logic                    tx_line_o;
  logic                    irq_o;

  uart_tracker sb;
  logic        line_plan[$];
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 51;
  int unsigned read_pct = 7;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned op_count[4] = '{0, 0, 0, 0};
  int unsigned frames_offered = 0;

  uart_peripheral u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .tx_data_i   (tx_data_i),
    .rx_line_i   (rx_line_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .tx_line_o   (tx_line_o),
    .irq_o       (irq_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receive side: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_reply(read_data_o, tx_line_o, irq_o);
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [8:0] data, input logic lvl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    tx_data_i = data;
    rx_line_i = lvl;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sb.take_item(op, data, lvl);
    op_count[op]++;
  endtask

  // stop offering and let every owed reply come back
  task automatic drain();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LatencySettle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrWidth-1:0] idx, input logic [CfgWidth-1:0] value);
    @(negedge clk);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = value;
    @(negedge clk);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(input logic [15:0] div, input logic os8, input logic w9,
                                input logic [1:0] stp, input logic rxe, input logic txe,
                                input logic pe, input logic ie);
    drain();
    write_reg(REG_BAUD_DIVISOR, div);
    write_reg(REG_OVERSAMPLE_BY8, CfgWidth'(os8));
    write_reg(REG_WORD_LENGTH_9, CfgWidth'(w9));
    write_reg(REG_STOP_BITS, CfgWidth'(stp));
    write_reg(REG_RX_ENABLE, CfgWidth'(rxe));
    write_reg(REG_TX_ENABLE, CfgWidth'(txe));
    write_reg(REG_PORT_ENABLE, CfgWidth'(pe));
    write_reg(REG_RX_IRQ_ENABLE, CfgWidth'(ie));
  endtask

  // queue up receive line levels: mostly clean frames, some broken ones
  task automatic plan_line();
    int unsigned p, n, kind, i;
    logic [8:0]  w;
    logic        stop_lvl;
    p = sb.bit_period();
    n = sb.data_bits();
    kind = $urandom_range(99);
    if (p > 64) begin
      // frames far too long for the run: just edges and idle
      repeat ($urandom_range(1, 20)) line_plan.push_back(1'($urandom));
    end else if (kind < 65) begin
      w = 9'($urandom);
      stop_lvl = ($urandom_range(9) != 0);
      repeat (p) line_plan.push_back(1'b0);
      for (i = 0; i < n; i++) repeat (p) line_plan.push_back(w[i]);
      repeat (p) line_plan.push_back(stop_lvl);
      repeat ($urandom_range(0, p)) line_plan.push_back(1'b1);
      frames_offered++;
    end else if (kind < 75) begin
      // low pulse that is gone by mid start bit
      repeat ($urandom_range(1, p / 2 - 1)) line_plan.push_back(1'b0);
      repeat (p) line_plan.push_back(1'b1);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) line_plan.push_back(1'($urandom));
    end else begin
      repeat ($urandom_range(1, 2 * p)) line_plan.push_back(1'b1);
    end
  endtask

  task automatic send_random_item();
    int unsigned r;
    logic        lvl;
    r = $urandom_range(99);
    if (r < read_pct) begin
      // driver style: status first, then the data register when something is flagged
      send_item(OP_STATUS_READ, 9'($urandom), 1'($urandom));
      if (sb.rxne || sb.ore || sb.fe) send_item(OP_DATA_READ, 9'($urandom), 1'($urandom));
    end else if (r < read_pct + 3) begin
      send_item(OP_DATA_READ, 9'($urandom), 1'($urandom));
    end else if (r < read_pct + 8) begin
      if (!sb.hold_full || $urandom_range(3) == 0)
        send_item(OP_DATA_WRITE, 9'($urandom_range(0, 511)), 1'($urandom));
      else
        send_item(OP_STATUS_READ, 9'($urandom), 1'($urandom));
    end else begin
      if (line_plan.size() == 0) plan_line();
      lvl = line_plan.pop_front();
      send_item(OP_TICK, 9'($urandom), lvl);
    end
  endtask

  initial begin
    int unsigned ph, k, items_in_phase;
    logic [15:0] div;
    logic        os8;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // port still off after reset: register access only, ticks move nothing
    send_item(OP_STATUS_READ, 9'h000, 1'b0);
    send_item(OP_DATA_READ, 9'h1FF, 1'b1);
    send_item(OP_DATA_WRITE, 9'h1FF, 1'b0);
    send_item(OP_DATA_WRITE, 9'h000, 1'b1);
    send_item(OP_TICK, 9'h1FF, 1'b0);
    send_item(OP_TICK, 9'h000, 1'b1);
    send_item(OP_STATUS_READ, 9'h1FF, 1'b1);

    // zero divisor, nine bits, one and a half stop bits, everything on
    apply_settings(16'h0000, 1'b0, 1'b1, STOP_ONE_HALF, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(OP_DATA_WRITE, 9'h1FF, 1'b1);
    send_item(OP_TICK, 9'h0AA, 1'b1);
    send_item(OP_TICK, 9'h155, 1'b0);
    send_item(OP_TICK, 9'h000, 1'b0);
    send_item(OP_TICK, 9'h1FF, 1'b1);
    send_item(OP_STATUS_READ, 9'h000, 1'b0);
    send_item(OP_DATA_READ, 9'h000, 1'b0);
    send_item(OP_DATA_READ, 9'h1FF, 1'b1);
    send_item(OP_DATA_WRITE, 9'h155, 1'b0);
    send_item(OP_TICK, 9'h000, 1'b0);
    send_item(OP_TICK, 9'h1FF, 1'b1);
    send_item(OP_STATUS_READ, 9'h1FF, 1'b0);
    send_item(OP_DATA_WRITE, 9'h0AA, 1'b1);

    for (ph = 0; ph < PhaseCount; ph++) begin
      if (ph < 5) begin
        send_idle_pct = 37;
        recv_idle_pct = 51;
      end else if (ph < 10) begin
        send_idle_pct = 51;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      os8 = ($urandom_range(99) < 70);
      div = os8 ? 16'($urandom_range(0, 16'h1F)) : 16'($urandom_range(0, 24));
      if (ph == 4) begin
        div = 16'hFFFF;
        os8 = 1'b0;
      end
      if (ph == 8) begin
        div = 16'hFFFF;
        os8 = 1'b1;
      end
      if (ph == 6) div = 16'h0000;
      // reads rare in some phases so words pile up into overruns
      read_pct = (ph % 3 == 2) ? 1 : 7;
      apply_settings(div, os8, 1'($urandom), 2'(ph % 4), ph != 9, ph != 7, ph != 11,
                     ph % 3 != 1);
      items_in_phase = (ph == 4 || ph == 8) ? 40 : 125;
      for (k = 0; k < items_in_phase; k++) begin
        if (ph == 2 && k == 20) hold_request = 1'b1;
        send_random_item();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("summary: %0d transactions in, %0d replies checked over %0d register settings",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], sb.checked,
             PhaseCount + 1);
    $display("summary: %0d ticks, %0d status reads, %0d data reads, %0d writes, %0d rx frames",
             op_count[OP_TICK], op_count[OP_STATUS_READ], op_count[OP_DATA_READ],
             op_count[OP_DATA_WRITE], frames_offered);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/uart_pkg.sv
src/uart_peripheral.sv
test/testbench.sv
